FILE: sv/tak_pkg.sv
// Package for the tilt angle Kalman fusion block: types, constants and the microprogram.
package tak_pkg;

  localparam logic signed [31:0] OneQ30   = 32'sd1073741824;
  localparam logic signed [31:0] Deg360   = 32'sd23592960;
  localparam logic signed [31:0] SatMax   = 32'sh7fffffff;
  localparam logic signed [31:0] SatMin   = 32'sh80000000;
  localparam int unsigned        PcW      = 6;
  localparam logic [PcW-1:0]     PcKalman = 6'd0;
  localparam logic [PcW-1:0]     PcCompl  = 6'd32;
  localparam logic [PcW-1:0]     PcLast   = 6'd37;

  localparam logic [2:0] RegMode = 3'd0;
  localparam logic [2:0] RegQa   = 3'd1;
  localparam logic [2:0] RegQg   = 3'd2;
  localparam logic [2:0] RegMr   = 3'd3;
  localparam logic [2:0] RegT    = 3'd4;
  localparam logic [2:0] RegW    = 3'd5;

  typedef enum logic [2:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_WRHI, OP_WRLO
  } op_e;

  typedef enum logic [4:0] {
    O_ANGLE, O_BIAS, O_RATE, O_P00, O_P01, O_P10, O_P11, O_ACCEL, O_GYRO,
    O_ERR, O_E, O_K0, O_K1, O_D0, O_D1, O_TMP,
    O_QA, O_QG, O_MR, O_T, O_W, O_ONE, O_ZERO, O_DEG360
  } opnd_e;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DIVW, ST_DONE} state_e;

  typedef struct packed {
    op_e   op;
    opnd_e a;
    opnd_e b;
    opnd_e dst;
    logic  last;
  } uinstr_t;

  function automatic uinstr_t ucode(input logic [PcW-1:0] pc);
    uinstr_t u;
    u = '{OP_ADD, O_ZERO, O_ZERO, O_TMP, 1'b1};
    unique case (pc)
      // Kalman: predict
      6'd0:  u = '{OP_SUB, O_GYRO,  O_BIAS, O_RATE,  1'b0};
      6'd1:  u = '{OP_MUL, O_RATE,  O_T,    O_TMP,   1'b0};
      6'd2:  u = '{OP_ADD, O_ANGLE, O_TMP,  O_ANGLE, 1'b0};
      6'd3:  u = '{OP_SUB, O_QA,    O_P01,  O_D0,    1'b0};
      6'd4:  u = '{OP_SUB, O_D0,    O_P10,  O_D0,    1'b0};
      6'd5:  u = '{OP_SUB, O_ZERO,  O_P11,  O_D1,    1'b0};
      6'd6:  u = '{OP_MUL, O_D0,    O_T,    O_TMP,   1'b0};
      6'd7:  u = '{OP_ADD, O_P00,   O_TMP,  O_P00,   1'b0};
      6'd8:  u = '{OP_MUL, O_D1,    O_T,    O_TMP,   1'b0};
      6'd9:  u = '{OP_ADD, O_P01,   O_TMP,  O_P01,   1'b0};
      6'd10: u = '{OP_ADD, O_P10,   O_TMP,  O_P10,   1'b0};
      6'd11: u = '{OP_MUL, O_QG,    O_T,    O_TMP,   1'b0};
      6'd12: u = '{OP_ADD, O_P11,   O_TMP,  O_P11,   1'b0};
      // gains
      6'd13: u = '{OP_SUB, O_ACCEL, O_ANGLE, O_ERR,  1'b0};
      6'd14: u = '{OP_ADD, O_MR,    O_P00,  O_E,     1'b0};
      6'd15: u = '{OP_DIV, O_P00,   O_E,    O_K0,    1'b0};
      6'd16: u = '{OP_DIV, O_P10,   O_E,    O_K1,    1'b0};
      // covariance correction: rows using old P00/P01 go first
      6'd17: u = '{OP_MUL, O_K1,    O_P00,  O_TMP,   1'b0};
      6'd18: u = '{OP_SUB, O_P10,   O_TMP,  O_P10,   1'b0};
      6'd19: u = '{OP_MUL, O_K1,    O_P01,  O_TMP,   1'b0};
      6'd20: u = '{OP_SUB, O_P11,   O_TMP,  O_P11,   1'b0};
      6'd21: u = '{OP_MUL, O_K0,    O_P01,  O_TMP,   1'b0};
      6'd22: u = '{OP_SUB, O_P01,   O_TMP,  O_P01,   1'b0};
      6'd23: u = '{OP_MUL, O_K0,    O_P00,  O_TMP,   1'b0};
      6'd24: u = '{OP_SUB, O_P00,   O_TMP,  O_P00,   1'b0};
      // state correction and wrap
      6'd25: u = '{OP_MUL, O_ERR,   O_K0,   O_TMP,   1'b0};
      6'd26: u = '{OP_ADD, O_ANGLE, O_TMP,  O_ANGLE, 1'b0};
      6'd27: u = '{OP_MUL, O_ERR,   O_K1,   O_TMP,   1'b0};
      6'd28: u = '{OP_ADD, O_BIAS,  O_TMP,  O_BIAS,  1'b0};
      6'd29: u = '{OP_SUB, O_GYRO,  O_BIAS, O_RATE,  1'b0};
      6'd30: u = '{OP_WRHI, O_ANGLE, O_ZERO, O_ANGLE, 1'b0};
      6'd31: u = '{OP_WRLO, O_ANGLE, O_ZERO, O_ANGLE, 1'b1};
      // complementary blend
      6'd32: u = '{OP_MUL, O_GYRO,  O_T,    O_TMP,   1'b0};
      6'd33: u = '{OP_ADD, O_ANGLE, O_TMP,  O_TMP,   1'b0};
      6'd34: u = '{OP_SUB, O_ONE,   O_W,    O_D1,    1'b0};
      6'd35: u = '{OP_MUL, O_D1,    O_TMP,  O_D1,    1'b0};
      6'd36: u = '{OP_MUL, O_W,     O_ACCEL, O_TMP,  1'b0};
      6'd37: u = '{OP_ADD, O_TMP,   O_D1,   O_ANGLE, 1'b1};
      default: u = '{OP_ADD, O_ZERO, O_ZERO, O_TMP, 1'b1};
    endcase
    return u;
  endfunction

endpackage

FILE: sv/tak_alu.sv
// Shared saturating add, subtract, Q2.30 multiply and angle wrap unit.
module tak_alu (
  input  tak_pkg::op_e        op_i,
  input  logic signed [31:0]  a_i,
  input  logic signed [31:0]  b_i,
  output logic signed [31:0]  res_o
);
  import tak_pkg::*;

  logic signed [63:0] prod;
  logic signed [64:0] prod_rnd;
  logic signed [64:0] prod_sh;
  logic signed [32:0] sum;
  logic signed [31:0] mul_sat;

  always_comb begin
    prod     = a_i * b_i;
    prod_rnd = {prod[63], prod} + 65'sd536870912;
    prod_sh  = prod_rnd >>> 30;
    if (prod_sh > 65'sd2147483647) mul_sat = SatMax;
    else if (prod_sh < -65'sd2147483648) mul_sat = SatMin;
    else mul_sat = prod_sh[31:0];

    if (op_i == OP_SUB) sum = {a_i[31], a_i} - {b_i[31], b_i};
    else sum = {a_i[31], a_i} + {b_i[31], b_i};

    unique case (op_i)
      OP_ADD, OP_SUB: begin
        if (sum[32] != sum[31]) res_o = sum[32] ? SatMin : SatMax;
        else res_o = sum[31:0];
      end
      OP_MUL:  res_o = mul_sat;
      OP_WRHI: res_o = (a_i > Deg360) ? a_i - Deg360 : a_i;
      OP_WRLO: res_o = (a_i < 0) ? a_i + Deg360 : a_i;
      default: res_o = '0;
    endcase
  end

endmodule

FILE: sv/tak_div.sv
// Radix-2 restoring divider for the gain (num * 2^30) / den with saturation.
module tak_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] num_i,
  input  logic signed [31:0] den_i,
  output logic               done_o,
  output logic signed [31:0] quot_o
);
  import tak_pkg::*;

  localparam int unsigned DivBits = 62;
  localparam int unsigned CntW    = $clog2(DivBits + 1);

  logic [DivBits-1:0] dvd_q, dvd_d;
  logic [31:0]        rem_q, rem_d, dvs_q;
  logic [CntW-1:0]    cnt_q;
  logic               busy_q, neg_q, zero_q, done_q;
  logic signed [31:0] quot_q;
  logic [32:0]        trial;
  logic               qbit;
  logic [31:0]        num_mag, den_mag;

  assign num_mag = num_i[31] ? 32'(-num_i) : 32'(num_i);
  assign den_mag = den_i[31] ? 32'(-den_i) : 32'(den_i);

  always_comb begin
    trial = {rem_q, dvd_q[DivBits-1]};
    qbit  = trial >= {1'b0, dvs_q};
    rem_d = qbit ? 32'(trial - {1'b0, dvs_q}) : trial[31:0];
    dvd_d = {dvd_q[DivBits-2:0], qbit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DivBits);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q  <= {num_mag, 30'b0};
      rem_q  <= '0;
      dvs_q  <= den_mag;
      neg_q  <= num_i[31] ^ den_i[31];
      zero_q <= (den_i == '0);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        if (zero_q) quot_q <= '0;
        else if (neg_q) quot_q <= (dvd_q > DivBits'(64'h80000000)) ? SatMin
                                                                   : 32'(-dvd_q[31:0]);
        else quot_q <= (dvd_q > DivBits'(64'h7fffffff)) ? SatMax : dvd_q[31:0];
      end else begin
        dvd_q <= dvd_d;
        rem_q <= rem_d;
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) start_i |-> !busy_q)
    else $error("divider restarted while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> !busy_q)
    else $error("divider done while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni) start_i |=> busy_q)
    else $error("divider did not start");

endmodule

FILE: sv/tilt_angle_kalman_fusion.sv
// Top level: config registers, state registers, microsequencer and output register.
// Kalman item: 30 ALU steps, two gain divides and one output load.
// Complementary item: 6 ALU steps and one output load.
// No new request is taken until the result of the last one is loaded into the output register.
// The result register holds while stalled; a new request is taken meanwhile.
// Reset: asynchronous, active low; angle, bias and rate zero, covariance identity.
module tilt_angle_kalman_fusion (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] accel_angle_i,
  input  logic signed [31:0] gyro_rate_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] angle_estimate_o,
  output logic signed [31:0] angle_rate_o
);
  import tak_pkg::*;

  logic        mode_q;
  logic [30:0] qa_q, qg_q, mr_q, w_q;
  logic [29:0] t_q;

  logic signed [31:0] angle_q, bias_q, rate_q, p00_q, p01_q, p10_q, p11_q;
  logic signed [31:0] accel_q, gyro_q, err_q, e_q, k0_q, k1_q, d0_q, d1_q, tmp_q;

  state_e         state_q, state_d;
  logic [PcW-1:0] pc_q, pc_d;
  uinstr_t        ui;
  logic signed [31:0] opa, opb, alu_res, wr_data, div_q;
  logic           wr_en, div_start, div_done, load_out, out_free, accept;
  logic           out_valid_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      qa_q   <= 31'd1073742;
      qg_q   <= 31'd3221225;
      mr_q   <= 31'd536870912;
      t_q    <= 30'd5368709;
      w_q    <= 31'd21474836;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        RegMode: mode_q <= pwdata[0];
        RegQa:   qa_q   <= pwdata[30:0];
        RegQg:   qg_q   <= pwdata[30:0];
        RegMr:   mr_q   <= pwdata[30:0];
        RegT:    t_q    <= pwdata[29:0];
        RegW:    w_q    <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      RegMode: prdata = {31'b0, mode_q};
      RegQa:   prdata = {1'b0, qa_q};
      RegQg:   prdata = {1'b0, qg_q};
      RegMr:   prdata = {1'b0, mr_q};
      RegT:    prdata = {2'b0, t_q};
      RegW:    prdata = {1'b0, w_q};
      default: prdata = '0;
    endcase
  end

  function automatic logic signed [31:0] sel(input opnd_e o);
    unique case (o)
      O_ANGLE:  return angle_q;
      O_BIAS:   return bias_q;
      O_RATE:   return rate_q;
      O_P00:    return p00_q;
      O_P01:    return p01_q;
      O_P10:    return p10_q;
      O_P11:    return p11_q;
      O_ACCEL:  return accel_q;
      O_GYRO:   return gyro_q;
      O_ERR:    return err_q;
      O_E:      return e_q;
      O_K0:     return k0_q;
      O_K1:     return k1_q;
      O_D0:     return d0_q;
      O_D1:     return d1_q;
      O_TMP:    return tmp_q;
      O_QA:     return {1'b0, qa_q};
      O_QG:     return {1'b0, qg_q};
      O_MR:     return {1'b0, mr_q};
      O_T:      return {2'b0, t_q};
      O_W:      return {1'b0, w_q};
      O_ONE:    return OneQ30;
      O_DEG360: return Deg360;
      default:  return '0;
    endcase
  endfunction

  assign ui = ucode(pc_q);

  always_comb begin
    opa = sel(ui.a);
    opb = sel(ui.b);
  end

  tak_alu u_alu (
    .op_i  (ui.op),
    .a_i   (opa),
    .b_i   (opb),
    .res_o (alu_res)
  );

  tak_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (opa),
    .den_i   (opb),
    .done_o  (div_done),
    .quot_o  (div_q)
  );

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d   = state_q;
    pc_d      = pc_q;
    wr_en     = 1'b0;
    wr_data   = alu_res;
    div_start = 1'b0;
    load_out  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          pc_d    = mode_q ? PcCompl : PcKalman;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (ui.op == OP_DIV) begin
          div_start = 1'b1;
          state_d   = ST_DIVW;
        end else begin
          wr_en = 1'b1;
          if (ui.last) begin
            state_d = ST_DONE;
          end else begin
            pc_d = pc_q + 1'b1;
          end
        end
      end
      ST_DIVW: begin
        if (div_done) begin
          wr_en   = 1'b1;
          wr_data = div_q;
          pc_d    = pc_q + 1'b1;
          state_d = ST_RUN;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
      angle_q     <= '0;
      bias_q      <= '0;
      rate_q      <= '0;
      p00_q       <= OneQ30;
      p01_q       <= '0;
      p10_q       <= '0;
      p11_q       <= OneQ30;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      if (load_out) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      if (wr_en) begin
        case (ui.dst)
          O_ANGLE: angle_q <= wr_data;
          O_BIAS:  bias_q  <= wr_data;
          O_RATE:  rate_q  <= wr_data;
          O_P00:   p00_q   <= wr_data;
          O_P01:   p01_q   <= wr_data;
          O_P10:   p10_q   <= wr_data;
          O_P11:   p11_q   <= wr_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      accel_q <= accel_angle_i;
      gyro_q  <= gyro_rate_i;
    end
    if (wr_en) begin
      case (ui.dst)
        O_ERR:   err_q <= wr_data;
        O_E:     e_q   <= wr_data;
        O_K0:    k0_q  <= wr_data;
        O_K1:    k1_q  <= wr_data;
        O_D0:    d0_q  <= wr_data;
        O_D1:    d1_q  <= wr_data;
        O_TMP:   tmp_q <= wr_data;
        default: ;
      endcase
    end
    if (load_out) begin
      angle_estimate_o <= angle_q;
      angle_rate_o     <= rate_q;
    end
  end

  assign out_valid_o = out_valid_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> in_stall_o)
    else $error("request accepted but sequencer did not start");
  assert property (@(posedge clk_i) disable iff (!rst_ni) div_done |-> state_q == ST_DIVW)
    else $error("divider result arrived outside divide wait");
  assert property (@(posedge clk_i) disable iff (!rst_ni) state_q == ST_RUN |-> pc_q <= PcLast)
    else $error("microprogram counter out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni) load_out |=> out_valid_o)
    else $error("result load did not raise valid");

endmodule

FILE: tb/sv/tb_tilt_angle_kalman_fusion.sv
// Testbench for tilt_angle_kalman_fusion: random and directed samples checked against a predictor.
module tb_tilt_angle_kalman_fusion;
  timeunit 1ns;
  timeprecision 1ps;
  import tak_pkg::*;

  typedef struct {
    logic signed [31:0] accel;
    logic signed [31:0] gyro;
  } sample_t;

  typedef struct {
    logic signed [31:0] angle;
    logic signed [31:0] rate;
  } fused_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [31:0] accel_angle_i = '0, gyro_rate_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [31:0] angle_estimate_o, angle_rate_o;

  tilt_angle_kalman_fusion uut (.*);

  always #6 clk_i = ~clk_i;

  // predictor state
  logic        cfg_mode;
  longint      cfg_qa, cfg_qg, cfg_r, cfg_t, cfg_w;
  longint      est_angle, est_bias, est_rate;
  longint      cov [4];

  sample_t sample_q[$];
  fused_t  fused_q[$];
  int      errors = 0;
  bit      calm = 1'b0;   // no idling near the end
  bit      hold_off = 1'b0;
  int      hold_len = 0;

  function automatic longint sat(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint mulq(longint a, longint b);
    return sat((a * b + 64'sd536870912) >>> 30);
  endfunction

  function automatic longint gainq(longint p, longint e);
    if (e == 0) return 0;
    return sat((p * 64'sd1073741824) / e);
  endfunction

  task automatic predict_reset();
    cfg_mode = 1'b0; cfg_qa = 1073742; cfg_qg = 3221225; cfg_r = 536870912;
    cfg_t = 5368709; cfg_w = 21474836;
    est_angle = 0; est_bias = 0; est_rate = 0;
    cov[0] = 1073741824; cov[1] = 0; cov[2] = 0; cov[3] = 1073741824;
  endtask

  task automatic fuse_sample(sample_t s);
    longint acc, gyr, ang, bias, p00, p01, p10, p11, err, e, k0, k1, t0, t1, d0, d1, pred;
    fused_t f;
    acc = s.accel; gyr = s.gyro; ang = est_angle;
    if (!cfg_mode) begin
      bias = est_bias; p00 = cov[0]; p01 = cov[1]; p10 = cov[2]; p11 = cov[3];
      est_rate = sat(gyr - bias);
      ang = sat(ang + mulq(est_rate, cfg_t));
      d0 = sat(sat(cfg_qa - p01) - p10);
      d1 = sat(-p11);
      p00 = sat(p00 + mulq(d0, cfg_t));
      p01 = sat(p01 + mulq(d1, cfg_t));
      p10 = sat(p10 + mulq(d1, cfg_t));
      p11 = sat(p11 + mulq(cfg_qg, cfg_t));
      err = sat(acc - ang);
      e = sat(cfg_r + p00);
      k0 = gainq(p00, e);
      k1 = gainq(p10, e);
      t0 = p00; t1 = p01;
      p00 = sat(p00 - mulq(k0, t0));
      p01 = sat(p01 - mulq(k0, t1));
      p10 = sat(p10 - mulq(k1, t0));
      p11 = sat(p11 - mulq(k1, t1));
      ang = sat(ang + mulq(err, k0));
      bias = sat(bias + mulq(err, k1));
      est_rate = sat(gyr - bias);
      if (ang > Deg360) ang -= Deg360;
      if (ang < 0) ang += Deg360;
      est_bias = bias;
      cov[0] = p00; cov[1] = p01; cov[2] = p10; cov[3] = p11;
    end else begin
      pred = sat(ang + mulq(gyr, cfg_t));
      ang = sat(mulq(cfg_w, acc) + mulq(64'sd1073741824 - cfg_w, pred));
    end
    est_angle = ang;
    f.angle = ang[31:0];
    f.rate = est_rate[31:0];
    fused_q.push_back(f);
  endtask

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  // register write; the predictor copy is updated alongside
  task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      RegMode: cfg_mode = val[0];
      RegQa:   cfg_qa = longint'(val[30:0]);
      RegQg:   cfg_qg = longint'(val[30:0]);
      RegMr:   cfg_r = longint'(val[30:0]);
      RegT:    cfg_t = longint'(val[29:0]);
      RegW:    cfg_w = longint'(val[30:0]);
      default: ;
    endcase
  endtask

  // driver: predicts when a request is accepted
  int gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        fuse_sample(sample_q.pop_front());
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (gap > 0) begin
          gap <= gap - 1;
          in_valid_i <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
          gap <= $urandom_range(0, 2);
          in_valid_i <= 1'b0;
        end else if (sample_q.size() > (in_valid_i && !in_stall_o ? 0 : 1) - 1 &&
                     sample_q.size() > 0) begin
          in_valid_i <= 1'b1;
          accel_angle_i <= sample_q[0].accel;
          gyro_rate_i <= sample_q[0].gyro;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall
  int stall_left = 0;
  always @(posedge clk_i) begin
    fused_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (fused_q.size() == 0) begin
          $display("unexpected result: angle %0d rate %0d", angle_estimate_o, angle_rate_o);
          errors++;
        end else begin
          want = fused_q.pop_front();
          if (angle_estimate_o !== want.angle)
            report("angle_estimate", angle_estimate_o, want.angle);
          if (angle_rate_o !== want.rate) report("angle_rate", angle_rate_o, want.rate);
        end
      end
      if (hold_off) begin
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall_i <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left <= $urandom_range(0, 2);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // long receiver hold-off, counted in its own process
  always @(posedge clk_i) begin
    if (hold_len > 0) begin
      hold_off <= 1'b1;
      hold_len <= hold_len - 1;
    end else begin
      hold_off <= 1'b0;
    end
  end

  function automatic sample_t rnd_sample(bit narrow);
    sample_t s;
    if (narrow) begin
      s.accel = $signed($urandom_range(0, 23592960)) - 32'sd2000000;
      s.gyro = $signed($urandom_range(0, 2 ** 24)) - 32'sd8388608;
    end else begin
      s.accel = $urandom;
      s.gyro = $urandom;
    end
    return s;
  endfunction

  task automatic drain();
    wait (sample_q.size() == 0 && !in_valid_i);
    wait (fused_q.size() == 0);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic push(logic signed [31:0] a, logic signed [31:0] g);
    sample_t s;
    s.accel = a; s.gyro = g;
    sample_q.push_back(s);
  endtask

  initial begin
    int phase;
    predict_reset();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: extremes in Kalman mode
    push(0, 0); push(32'sh7fffffff, 32'sh7fffffff); push(32'sh80000000, 32'sh80000000);
    push(32'sh7fffffff, 32'sh80000000); push(32'sh80000000, 32'sh7fffffff);
    push(Deg360 + 1, 0); push(-1, 0); push(Deg360, 0); push(32'hffffffff, 32'h55555555);
    push(32'haaaaaaaa, 32'h33333333);
    drain();
    // zero innovation variance: P00 = -R after prediction is hard; large R, Qa, Qg and T path instead
    cfg_write(RegMr, 32'hffffffff); // masked to 31 bits
    cfg_write(RegQa, 32'h7fffffff);
    cfg_write(RegQg, 32'h7fffffff);
    cfg_write(RegT, 32'h3fffffff);
    push(100, 100); push(32'sh7fffffff, 0); push(32'sh80000000, 32'sh80000000); push(0, 5);
    drain();
    // complementary: weight extremes including above one
    cfg_write(RegMode, 32'h1);
    cfg_write(RegW, 32'h0);
    push(32'sh7fffffff, 32'sh7fffffff); push(5, -5);
    drain();
    cfg_write(RegW, 32'h40000000);
    push(32'sh80000000, 1); push(12345, 0);
    drain();
    cfg_write(RegW, 32'h7fffffff);
    push(32'sh7fffffff, 32'sh80000000); push(1000, 1000);
    drain();
    cfg_write(RegT, 32'h1);
    cfg_write(RegW, 32'd21474836);
    push(-1, -1);
    drain();
    // random phases over several settings
    for (phase = 0; phase < 8; phase++) begin
      cfg_write(RegMode, (phase % 3 == 2) ? 32'h1 : 32'h0);
      if (phase == 0) begin
        cfg_write(RegQa, 1073742); cfg_write(RegQg, 3221225);
        cfg_write(RegMr, 536870912); cfg_write(RegT, 5368709);
      end else begin
        cfg_write(RegQa, $urandom_range(0, 1 << 24));
        cfg_write(RegQg, $urandom_range(0, 1 << 24));
        cfg_write(RegMr, (phase == 7) ? $urandom : $urandom_range(1, 1 << 30));
        cfg_write(RegT, (phase == 6) ? $urandom : $urandom_range(1, 1 << 25));
      end
      cfg_write(RegW, $urandom_range(0, 1 << 30));
      if (phase == 1) hold_len = 300;
      if (phase == 7) calm = 1'b1;
      repeat (150) sample_q.push_back(rnd_sample($urandom_range(0, 4) != 0));
      drain();
    end
    if (errors == 0) $display("tb_tilt_angle_kalman_fusion: done, clean");
    else $display("tb_tilt_angle_kalman_fusion: done, errors");
    $finish;
  end

  initial begin
    #40ms;
    $display("tb_tilt_angle_kalman_fusion: done, errors");
    $finish;
  end
endmodule

FILE: files.f
sv/tak_pkg.sv
sv/tak_alu.sv
sv/tak_div.sv
sv/tilt_angle_kalman_fusion.sv
tb/sv/tb_tilt_angle_kalman_fusion.sv
